[src/isa_pkg.sv]
// Shared types and constants for the indexed shift array.
// Used by isa_ctrl, isa_dpath and indexed_shift_array_core; no dependencies.
package isa_pkg;

	// Array geometry and field widths
	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int ACT_W  = 2;
	localparam int STAT_W = 2;
	localparam int OUT_CNT_W = 5;

	// Stream payload widths, padded to whole bytes
	localparam int S_DATA_W = ((ACT_W + IDX_W + WORD_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((WORD_W + OUT_CNT_W + STAT_W + 7) / 8) * 8;

	// Request action codes
	typedef enum logic [ACT_W-1:0] {
		ACT_READ   = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_INSERT = 2'd2,
		ACT_REMOVE = 2'd3
	} action_e_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_e_t;

	// Datapath operation chosen by the controller
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_READ   = 3'd1,
		OP_APPEND = 3'd2,
		OP_INSERT = 3'd3,
		OP_REMOVE = 3'd4
	} op_e_t;

	// Controller to datapath
	typedef struct packed {
		logic      capture;
		logic      exec;
		op_e_t     op;
		status_e_t status;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		action_e_t action;
		logic      empty;
		logic      full;
		logic      idx_ge_count;
		logic      idx_gt_count;
	} dp_stat_t;

endpackage

[src/isa_dpath.sv]
// Datapath of the indexed shift array: request register, row of shifting
// cells, fill count and result register. Depends on isa_pkg.
module isa_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  isa_pkg::dp_cmd_t                 cmd,
	input  logic [isa_pkg::ACT_W-1:0]        action,
	input  logic [isa_pkg::IDX_W-1:0]        index,
	input  logic signed [isa_pkg::WORD_W-1:0] value,
	output isa_pkg::dp_stat_t                stat,
	output logic signed [isa_pkg::WORD_W-1:0] read_value,
	output logic [isa_pkg::OUT_CNT_W-1:0]    count,
	output isa_pkg::status_e_t               status
);
	import isa_pkg::*;

	logic [ACT_W-1:0]  action_q;
	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] value_q;
	logic [CNT_W-1:0]  fill_count_q;
	logic [WORD_W-1:0] entry_q [DEPTH];
	logic [WORD_W-1:0] read_value_q;
	status_e_t         status_q;
	logic [CNT_W-1:0]  idx_ext;

	// Request register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			idx_q    <= index;
			value_q  <= value;
		end
	end

	// Flags for the controller's decision
	assign idx_ext = CNT_W'(idx_q);
	assign stat.action       = action_e_t'(action_q);
	assign stat.empty        = (fill_count_q == '0);
	assign stat.full         = (fill_count_q == CNT_W'(DEPTH));
	assign stat.idx_ge_count = (idx_ext >= fill_count_q);
	assign stat.idx_gt_count = (idx_ext > fill_count_q);

	// Cells: each loads the new word, its lower or its upper neighbour
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] below_w;
		logic [WORD_W-1:0] above_w;

		if (i == 0) begin : g_lo
			assign below_w = value_q;
		end else begin : g_lo
			assign below_w = entry_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_hi
			assign above_w = entry_q[i];
		end else begin : g_hi
			assign above_w = entry_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				unique case (cmd.op)
					OP_APPEND: begin
						if (fill_count_q[IDX_W-1:0] == IDX_W'(i))
							entry_q[i] <= value_q;
					end
					OP_INSERT: begin
						if (idx_q == IDX_W'(i))
							entry_q[i] <= value_q;
						else if (idx_q < IDX_W'(i))
							entry_q[i] <= below_w;
					end
					OP_REMOVE: begin
						if (idx_q <= IDX_W'(i))
							entry_q[i] <= above_w;
					end
					default: ;
				endcase
			end
		end
	end

	// Live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
		end else if (cmd.exec) begin
			unique case (cmd.op)
				OP_APPEND, OP_INSERT: fill_count_q <= fill_count_q + CNT_W'(1);
				OP_REMOVE:            fill_count_q <= fill_count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	// Result register; count follows the fill count, which holds until the next execute
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_value_q <= (cmd.op == OP_READ) ? entry_q[idx_q] : '0;
			status_q     <= cmd.status;
		end
	end

	assign read_value = read_value_q;
	assign count      = OUT_CNT_W'(fill_count_q);
	assign status     = status_q;

endmodule

[src/isa_ctrl.sv]
// Controller of the indexed shift array: accept/execute sequencing, error
// decode and the result valid flag. Depends on isa_pkg.
module isa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  isa_pkg::dp_stat_t stat,
	output isa_pkg::dp_cmd_t  cmd
);
	import isa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_e_t;

	state_e_t  state_q;
	logic      out_valid_q;
	logic      exec_go;
	op_e_t     op_w;
	status_e_t st_w;

	assign s_tready = (state_q == S_IDLE);
	assign exec_go  = (state_q == S_EXEC) && (!out_valid_q || m_tready);

	// Outcome of the held request
	always_comb begin
		op_w = OP_NONE;
		st_w = ST_OK;
		unique case (stat.action)
			ACT_READ: begin
				if (stat.empty)             st_w = ST_EMPTY;
				else if (stat.idx_ge_count) st_w = ST_RANGE;
				else                        op_w = OP_READ;
			end
			ACT_APPEND: begin
				if (stat.full) st_w = ST_FULL;
				else           op_w = OP_APPEND;
			end
			ACT_INSERT: begin
				if (stat.full)              st_w = ST_FULL;
				else if (stat.idx_gt_count) st_w = ST_RANGE;
				else                        op_w = OP_INSERT;
			end
			ACT_REMOVE: begin
				if (stat.empty)             st_w = ST_EMPTY;
				else if (stat.idx_ge_count) st_w = ST_RANGE;
				else                        op_w = OP_REMOVE;
			end
			default: ;
		endcase
	end

	assign cmd.capture = s_tvalid && s_tready;
	assign cmd.exec    = exec_go;
	assign cmd.op      = exec_go ? op_w : OP_NONE;
	assign cmd.status  = st_w;

	// State machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (s_tvalid) state_q <= S_EXEC;
				S_EXEC:  if (exec_go)  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

[src/indexed_shift_array_core.sv]
// Top level of the indexed shift array: stream ports around isa_ctrl and
// isa_dpath. Depends on isa_pkg, isa_ctrl, isa_dpath.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-------------------------------------
//  request   | in  | s_tvalid/s_tready  | s_tdata: action, index, value
//  result    | out | m_tvalid/m_tready  | m_tdata: read_value, count, status
//
// Each item is first registered, then run on all cells at once in the execute
// state, which loads the result register. The two-state controller takes no
// new request until the current one has executed.
// The execute cycle waits while an earlier result is still held unaccepted.
// Reset clears the count and handshake state; cell contents are left as is.
module indexed_shift_array_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [1:0] action, [5:2] index, [37:6] value, [39:38] zero
	input  logic [isa_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] read_value, [36:32] count, [38:37] status, [39] zero
	output logic [isa_pkg::M_DATA_W-1:0]   m_tdata
);
	import isa_pkg::*;

	dp_cmd_t                  cmd;
	dp_stat_t                 stat;
	logic signed [WORD_W-1:0] read_value;
	logic [OUT_CNT_W-1:0]     count;
	status_e_t                status;

	isa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	isa_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.action     (s_tdata[ACT_W-1:0]),
		.index      (s_tdata[ACT_W +: IDX_W]),
		.value      (s_tdata[ACT_W + IDX_W +: WORD_W]),
		.stat       (stat),
		.read_value (read_value),
		.count      (count),
		.status     (status)
	);

	// Result packing
	assign m_tdata = {{(M_DATA_W - WORD_W - OUT_CNT_W - STAT_W){1'b0}},
		status, count, read_value};

	// Count never goes past the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= OUT_CNT_W'(DEPTH))
		else $error("count above capacity");

	// A request is held for execution before the next is taken
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken during execute");

	// A full report comes only with a full array
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status == ST_FULL) |-> (count == OUT_CNT_W'(DEPTH)))
		else $error("full status with room left");

	// An empty report comes only with an empty array
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status == ST_EMPTY) |-> (count == '0))
		else $error("empty status with entries present");

	// A non-zero read word only comes with an ok status
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && read_value != '0) |-> (status == ST_OK))
		else $error("read word on an error result");

endmodule
